// File: hw/rtl/rzs_pkg.sv
package rzs_pkg;

	localparam int SAMPLE_W = 16;
	localparam int COUNT_W  = 16;
	localparam int SUM_W    = 32;
	localparam int SQSUM_W  = 48;
	localparam int TOTAL_W  = 40;
	localparam int Z_W      = 26;
	localparam int MEAN_W   = 16;
	localparam int STD_W    = 16;
	localparam int STAT_W   = 2;

	localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STAT_W-1:0] STAT_CLR  = 2'd2;

	localparam logic ACT_CLEAR = 1'b1;

	localparam logic [STD_W-1:0] STD_ONE = 16'd256;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQ,
		ST_SQA,
		ST_L0,
		ST_L1,
		ST_L2,
		ST_L3,
		ST_L4,
		ST_VW,
		ST_SW,
		ST_MW,
		ST_ZS,
		ST_ZW,
		ST_DONE
	} state_t;

endpackage

// File: hw/rtl/rzs_mul.sv
module rzs_mul (
	input  logic        clk,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [63:0] p
);
	logic [63:0] p_q;

	always_ff @(posedge clk) begin
		p_q <= {32'd0, a} * {32'd0, b};
	end

	assign p = p_q;
endmodule

// File: hw/rtl/rzs_div.sv
// restoring divide, one quotient bit per cycle; quotient must fit 32 bits
module rzs_div (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [63:0] dividend,
	input  logic [31:0] divisor,
	output logic        busy,
	output logic [31:0] quot
);
	logic        busy_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] dvs_q;
	logic [32:0] trial;
	logic [32:0] diff;

	assign trial = {rem_q, quo_q[31]};
	assign diff  = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 5'd1;
			if (cnt_q == 5'd31) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= dividend[63:32];
			quo_q <= dividend[31:0];
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[32]) begin
				rem_q <= diff[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quot = quo_q;
endmodule

// File: hw/rtl/rzs_sqrt.sv
// floor square root, two radicand bits per cycle
module rzs_sqrt (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] radicand,
	output logic        busy,
	output logic [15:0] root
);
	logic        busy_q;
	logic [3:0]  cnt_q;
	logic [31:0] rad_q;
	logic [17:0] rem_q;
	logic [15:0] root_q;
	logic [19:0] r;
	logic [19:0] t;
	logic [20:0] diff;

	assign r    = {rem_q, rad_q[31:30]};
	assign t    = {2'b00, root_q, 2'b01};
	assign diff = {1'b0, r} - {1'b0, t};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 4'd1;
			if (cnt_q == 4'd15) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rad_q <= {rad_q[29:0], 2'b00};
			if (!diff[20]) begin
				rem_q  <= diff[17:0];
				root_q <= {root_q[14:0], 1'b1};
			end else begin
				rem_q  <= r[17:0];
				root_q <= {root_q[14:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign root = root_q;
endmodule

// File: hw/rtl/running_z_score_accumulator_core.sv
// Running z-score accumulator.
// Input channel: sample_valid / sample_stall carry one word of action and
// sample (signed Q8.8). action clear empties count, sum and sum of squares
// and loads the total from initial_score; otherwise the sample joins the
// statistics and its z-score goes to a saturating Q32.8 total, unless the
// count is full. Output channel: result_valid / result_stall carry one
// word per input: total_score, step_z, running_mean, running_std, status.
// A clear goes straight to the done state and then the output register.
// A sample takes multiplier steps, then three divides (variance, mean, z)
// and a square root on the shared units; a full count skips the z divide.
// One word is in flight at a time; sample_stall is high while it is worked
// on. A finished word waits in the output register while result_stall is
// high and the next input may already be accepted.
// initial_score is written over the APB port at byte address 0 (64-bit
// data); it takes effect at the next clear.
// Reset clears the statistics, the total, initial_score and result_valid.
module running_z_score_accumulator_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [3:0]                  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic                        action,
	input  logic signed [15:0]          sample,
	output logic                        result_valid,
	input  logic                        result_stall,
	output logic signed [39:0]          total_score,
	output logic signed [25:0]          step_z,
	output logic signed [15:0]          running_mean,
	output logic [15:0]                 running_std,
	output logic [1:0]                  status
);
	import rzs_pkg::*;

	state_t state_q, state_d;

	logic [TOTAL_W-1:0] init_q;
	logic [COUNT_W-1:0] count_q;
	logic [SUM_W-1:0]   sum_q;
	logic [SQSUM_W-1:0] sqsum_q;
	logic [TOTAL_W-1:0] total_q;
	logic [SAMPLE_W-1:0] x_q;
	logic               upd_q;
	logic [STAT_W-1:0]  stat_q;
	logic [63:0]        lhs_q;
	logic [63:0]        sqv_q;
	logic [STD_W-1:0]   dev_q;
	logic [MEAN_W-1:0]  mean_q;
	logic [Z_W-1:0]     z_q;

	logic               out_v_q;
	logic [TOTAL_W-1:0] o_total_q;
	logic [Z_W-1:0]     o_z_q;
	logic [MEAN_W-1:0]  o_mean_q;
	logic [STD_W-1:0]   o_std_q;
	logic [STAT_W-1:0]  o_stat_q;

	logic        accept;
	logic        cfg_wr;
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;
	logic        div_start, div_busy;
	logic [63:0] div_dvd;
	logic [31:0] div_dvs;
	logic [31:0] div_quot;
	logic        sq_start, sq_busy;
	logic [15:0] sq_root;
	logic [SAMPLE_W-1:0] ax;
	logic [SUM_W-1:0]    abs_sum;
	logic [63:0]         var_num;
	logic [16:0]         dmean;
	logic [16:0]         dmag;
	logic [MEAN_W-1:0]   mq;
	logic [Z_W-1:0]      zq;
	logic [Z_W-1:0]      z_new;
	logic [TOTAL_W:0]    tsum;
	logic                out_free;

	assign pready = 1'b1;
	assign prdata = {24'd0, init_q};
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[3] == 1'b0);

	assign accept       = sample_valid && !sample_stall;
	assign sample_stall = (state_q != ST_IDLE);
	assign out_free     = !out_v_q || !result_stall;

	assign ax      = x_q[SAMPLE_W-1] ? (~x_q + 1'b1) : x_q;
	assign abs_sum = sum_q[SUM_W-1] ? (~sum_q + 1'b1) : sum_q;
	assign var_num = (lhs_q > sqv_q) ? (lhs_q - sqv_q) : 64'd0;
	assign dmean   = {x_q[SAMPLE_W-1], x_q} - {mean_q[MEAN_W-1], mean_q};
	assign dmag    = dmean[16] ? (~dmean + 1'b1) : dmean;
	assign mq      = div_quot[MEAN_W-1:0];
	assign zq      = div_quot[Z_W-1:0];
	assign z_new   = dmean[16] ? (~zq + 1'b1) : zq;
	assign tsum    = {total_q[TOTAL_W-1], total_q} +
		{{(TOTAL_W+1-Z_W){z_new[Z_W-1]}}, z_new};

	rzs_mul u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod)
	);

	rzs_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dvd),
		.divisor  (div_dvs),
		.busy     (div_busy),
		.quot     (div_quot)
	);

	rzs_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sq_start),
		.radicand (div_quot),
		.busy     (sq_busy),
		.root     (sq_root)
	);

	always_comb begin
		state_d   = state_q;
		mul_a     = '0;
		mul_b     = '0;
		div_start = 1'b0;
		div_dvd   = '0;
		div_dvs   = '0;
		sq_start  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (action == ACT_CLEAR) begin
						state_d = ST_DONE;
					end else if (count_q == {COUNT_W{1'b1}}) begin
						state_d = ST_L0;
					end else begin
						state_d = ST_SQ;
					end
				end
			end
			ST_SQ: begin
				mul_a   = {16'd0, ax};
				mul_b   = {16'd0, ax};
				state_d = ST_SQA;
			end
			ST_SQA: state_d = ST_L0;
			ST_L0: begin
				mul_a   = {16'd0, count_q};
				mul_b   = sqsum_q[31:0];
				state_d = ST_L1;
			end
			ST_L1: begin
				mul_a   = {16'd0, count_q};
				mul_b   = {16'd0, sqsum_q[47:32]};
				state_d = ST_L2;
			end
			ST_L2: begin
				mul_a   = abs_sum;
				mul_b   = abs_sum;
				state_d = ST_L3;
			end
			ST_L3: begin
				mul_a   = {16'd0, count_q};
				mul_b   = {16'd0, count_q};
				state_d = ST_L4;
			end
			ST_L4: begin
				div_start = 1'b1;
				div_dvd   = var_num;
				div_dvs   = prod[31:0];
				state_d   = ST_VW;
			end
			ST_VW: begin
				if (!div_busy) begin
					sq_start = 1'b1;
					state_d  = ST_SW;
				end
			end
			ST_SW: begin
				if (!sq_busy) begin
					div_start = 1'b1;
					div_dvd   = {32'd0, abs_sum};
					div_dvs   = {16'd0, count_q};
					state_d   = ST_MW;
				end
			end
			ST_MW: begin
				if (!div_busy) begin
					state_d = upd_q ? ST_ZS : ST_DONE;
				end
			end
			ST_ZS: begin
				div_start = 1'b1;
				div_dvd   = {39'd0, dmag, 8'd0};
				div_dvs   = {16'd0, dev_q};
				state_d   = ST_ZW;
			end
			ST_ZW: begin
				if (!div_busy) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q  <= '0;
			count_q <= '0;
			sum_q   <= '0;
			sqsum_q <= '0;
			total_q <= '0;
		end else begin
			if (cfg_wr) begin
				init_q <= pwdata[TOTAL_W-1:0];
			end
			if (state_q == ST_IDLE && accept) begin
				if (action == ACT_CLEAR) begin
					count_q <= '0;
					sum_q   <= '0;
					sqsum_q <= '0;
					total_q <= init_q;
				end else if (count_q != {COUNT_W{1'b1}}) begin
					count_q <= count_q + 1'b1;
					sum_q   <= sum_q + {{(SUM_W-SAMPLE_W){sample[SAMPLE_W-1]}}, sample};
				end
			end
			if (state_q == ST_SQA) begin
				sqsum_q <= sqsum_q + prod[SQSUM_W-1:0];
			end
			if (state_q == ST_ZW && !div_busy) begin
				if (!tsum[TOTAL_W] && tsum[TOTAL_W-1]) begin
					total_q <= {1'b0, {(TOTAL_W-1){1'b1}}};
				end else if (tsum[TOTAL_W] && !tsum[TOTAL_W-1]) begin
					total_q <= {1'b1, {(TOTAL_W-1){1'b0}}};
				end else begin
					total_q <= tsum[TOTAL_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && accept) begin
			x_q <= sample;
			z_q <= '0;
			if (action == ACT_CLEAR) begin
				stat_q <= STAT_CLR;
				upd_q  <= 1'b0;
				mean_q <= '0;
				dev_q  <= '0;
			end else if (count_q == {COUNT_W{1'b1}}) begin
				stat_q <= STAT_FULL;
				upd_q  <= 1'b0;
			end else begin
				stat_q <= STAT_OK;
				upd_q  <= 1'b1;
			end
		end
		if (state_q == ST_L1) begin
			lhs_q <= prod;
		end
		if (state_q == ST_L2) begin
			lhs_q <= lhs_q + {prod[31:0], 32'd0};
		end
		if (state_q == ST_L3) begin
			sqv_q <= prod;
		end
		if (state_q == ST_SW && !sq_busy) begin
			dev_q <= (sq_root == 16'd0) ? STD_ONE : sq_root;
		end
		if (state_q == ST_MW && !div_busy) begin
			mean_q <= sum_q[SUM_W-1] ? ((~mq) + 1'b1) : mq;
		end
		if (state_q == ST_ZW && !div_busy) begin
			z_q <= z_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			out_v_q <= 1'b1;
		end else if (!result_stall) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			o_total_q <= total_q;
			o_z_q     <= z_q;
			o_mean_q  <= mean_q;
			o_std_q   <= dev_q;
			o_stat_q  <= stat_q;
		end
	end

	assign result_valid = out_v_q;
	assign total_score  = o_total_q;
	assign step_z       = o_z_q;
	assign running_mean = o_mean_q;
	assign running_std  = o_std_q;
	assign status       = o_stat_q;

	a_units_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		!(div_busy && sq_busy))
		else $error("divider and square root busy together");

	a_std_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status != STAT_CLR) |-> (running_std != 16'd0))
		else $error("zero deviation on a sample word");

	a_clear_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && status == STAT_CLR) |->
		(step_z == 26'd0 && running_mean == 16'd0 && running_std == 16'd0))
		else $error("clear word carries statistics");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("sequencer idle after accept");
endmodule

// File: sim/running_z_score_accumulator_core_test.sv
`timescale 1ns / 1ps

module running_z_score_accumulator_core_test;
	import rzs_pkg::*;

	localparam longint TOTAL_HI = 64'sd549755813887;
	localparam longint TOTAL_LO = -64'sd549755813888;
	localparam longint Z_HI = 64'sd33554431;
	localparam longint Z_LO = -64'sd33554432;
	localparam longint unsigned COUNT_TOP = (64'd1 << COUNT_W) - 1;
	localparam logic [3:0] ADDR_INIT_SCORE = 4'd0;
	localparam logic ACT_SAMPLE = 1'b0;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct packed {
		logic signed [TOTAL_W-1:0] total;
		logic signed [Z_W-1:0]     z;
		logic signed [MEAN_W-1:0]  mean;
		logic [STD_W-1:0]          sdev;
		logic [STAT_W-1:0]         stat;
	} score_word_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic pready;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic action = 1'b0;
	logic signed [15:0] sample = '0;
	logic result_valid;
	logic result_stall = 1'b0;
	logic signed [39:0] total_score;
	logic signed [25:0] step_z;
	logic signed [15:0] running_mean;
	logic [15:0] running_std;
	logic [1:0] status;

	running_z_score_accumulator_core dut (.*);

	// predictor state
	longint shadow_init;
	longint unsigned n_samples;
	longint sum_x;
	longint unsigned sum_sq;
	longint score_acc;

	score_word_t expected_words[$];
	int mismatches = 0;
	int cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	initial forever #4 clk = ~clk;

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n)
			result_stall <= ($urandom_range(99) < stall_pct);
	end

	function automatic longint unsigned floor_sqrt(longint unsigned v);
		longint unsigned r = 0;
		for (int b = 31; b >= 0; b--) begin
			longint unsigned t = r | (64'd1 << b);
			if (t * t <= v)
				r = t;
		end
		return r;
	endfunction

	function automatic void current_stats(output longint m, output longint unsigned d);
		longint unsigned a, lhs, sq, var_q, s;
		a = (sum_x < 0) ? longint'(-sum_x) : longint'(sum_x);
		lhs = n_samples * sum_sq;
		sq = a * a;
		var_q = 0;
		m = sum_x / longint'(n_samples);
		if (lhs > sq)
			var_q = (lhs - sq) / (n_samples * n_samples);
		s = floor_sqrt(var_q);
		d = (s == 0) ? 256 : s;
	endfunction

	function automatic score_word_t predict_score(logic act, logic signed [15:0] x_in);
		score_word_t w;
		longint z = 0, m = 0, x, t;
		longint unsigned d = 0, ax;
		logic [STAT_W-1:0] st;
		if (act == ACT_CLEAR) begin
			n_samples = 0;
			sum_x = 0;
			sum_sq = 0;
			score_acc = shadow_init;
			st = STAT_CLR;
		end else if (n_samples >= COUNT_TOP) begin
			current_stats(m, d);
			st = STAT_FULL;
		end else begin
			x = x_in;
			ax = (x < 0) ? -x : x;
			n_samples++;
			sum_x = longint'(int'(sum_x + x));
			sum_sq = sum_sq + ax * ax;
			current_stats(m, d);
			z = ((x - m) * 256) / longint'(d);
			if (z > Z_HI) z = Z_HI;
			if (z < Z_LO) z = Z_LO;
			t = score_acc + z;
			if (t > TOTAL_HI) t = TOTAL_HI;
			if (t < TOTAL_LO) t = TOTAL_LO;
			score_acc = t;
			st = STAT_OK;
		end
		w.total = score_acc[TOTAL_W-1:0];
		w.z = z[Z_W-1:0];
		w.mean = m[MEAN_W-1:0];
		w.sdev = d[STD_W-1:0];
		w.stat = st;
		return w;
	endfunction

	always @(posedge clk) begin
		score_word_t got, want;
		if (arst_n && result_valid && !result_stall) begin
			got = '{total_score, step_z, running_mean, running_std, status};
			if (expected_words.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word %p", got);
			end else begin
				want = expected_words.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected %p got %p", want, got);
				end
			end
		end
	end

	task automatic send_word(logic act, logic signed [15:0] x);
		while ($urandom_range(99) < send_idle_pct) begin
			sample_valid <= 1'b0;
			@(posedge clk);
		end
		sample_valid <= 1'b1;
		action <= act;
		sample <= x;
		expected_words.insert(expected_words.size(), predict_score(act, x));
		@(negedge clk);
		while (sample_stall)
			@(negedge clk);
		@(posedge clk);
	endtask

	task automatic wait_drain();
		sample_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic write_init_score(longint v);
		wait_drain();
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= ADDR_INIT_SCORE;
		pwdata <= 64'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		shadow_init = longint'({{24{v[39]}}, v[39:0]});
	endtask

	function automatic logic signed [15:0] rand_sample();
		unique case ($urandom_range(3))
			0: return 16'($urandom);
			1: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
			2: return 16'($urandom_range(600)) - 16'sd300;
			default: return 16'sd2560 + 16'($urandom_range(64));
		endcase
	endfunction

	task automatic test_directed();
		send_word(ACT_SAMPLE, 16'sd0);
		send_word(ACT_SAMPLE, 16'sd0);
		send_word(ACT_SAMPLE, 16'sh7fff);
		send_word(ACT_SAMPLE, -16'sh8000);
		send_word(ACT_SAMPLE, 16'sh5555);
		send_word(ACT_SAMPLE, -16'sh5556);
		send_word(ACT_CLEAR, 16'sh7fff);
		send_word(ACT_SAMPLE, 16'sd256);
		send_word(ACT_SAMPLE, 16'sd256);
		send_word(ACT_SAMPLE, -16'sh8000);
		wait_drain();
		write_init_score(TOTAL_HI);
		send_word(ACT_CLEAR, 16'sd0);
		send_word(ACT_SAMPLE, 16'sd100);
		send_word(ACT_SAMPLE, 16'sh7fff);
		write_init_score(TOTAL_LO);
		send_word(ACT_CLEAR, 16'sd0);
		send_word(ACT_SAMPLE, 16'sd1);
		send_word(ACT_SAMPLE, -16'sh8000);
	endtask

	task automatic test_random(int count, int idle, int stall);
		send_idle_pct = idle;
		stall_pct = stall;
		for (int i = 0; i < count; i++)
			send_word(($urandom_range(19) == 0) ? ACT_CLEAR : ACT_SAMPLE, rand_sample());
		wait_drain();
	endtask

	initial begin
		shadow_init = 0;
		n_samples = 0;
		sum_x = 0;
		sum_sq = 0;
		score_acc = 0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		write_init_score(64'sd12345);
		test_random(450, 0, 0);
		write_init_score(-64'sd777);
		test_random(450, 71, 0);
		write_init_score(64'(longint'($urandom)));
		test_random(450, 0, 71);
		write_init_score(0);
		test_random(400, 38, 38);
		if (mismatches == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
